### hw/rtl/isra_pkg.sv
package isra_pkg;

	typedef struct packed {
		logic        opcode;
		logic [3:0]  target_index;
		logic [7:0]  band_index;
		logic [15:0] value;
	} isra_in_t;

	typedef struct packed {
		logic [3:0]  out_target;
		logic [31:0] abundance;
		logic        zero_denominator;
		logic        last;
	} isra_out_t;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic [1:0] REG_BANDS  = 2'd0;
	localparam logic [1:0] REG_TARGETS = 2'd1;
	localparam logic [1:0] REG_ITERS  = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_NUM,
		ST_NUM_END,
		ST_REC,
		ST_REC_END,
		ST_DEN,
		ST_DEN_END,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_EMIT
	} isra_state_t;

	// Control between sequencer and the shared MAC.
	typedef struct packed {
		logic clear;
		logic valid;
		logic mode;
	} isra_mac_ctl_t;

endpackage

### hw/rtl/isra_mac.sv
module isra_mac
	import isra_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  isra_mac_ctl_t ctl,
	input  logic [15:0]   op_a,
	input  logic [63:0]   op_b,
	output logic [63:0]   acc
);
	// mode 0: 16x32 product (b below 2^32); mode 1: 16x64 product, saturated.
	logic [15:0] a_s1;
	logic [63:0] b_s1;
	logic        v_s1, m_s1, c_s1;
	logic [47:0] p_lo_s2;
	logic [47:0] p_hi_s2;
	logic        v_s2, c_s2;
	logic [80:0] prod;
	logic [63:0] term;
	logic [64:0] sum;
	logic [63:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			c_s1 <= 1'b0;
			v_s2 <= 1'b0;
			c_s2 <= 1'b0;
			acc_q <= '0;
		end else begin
			v_s1 <= ctl.valid;
			c_s1 <= ctl.clear;
			v_s2 <= v_s1;
			c_s2 <= c_s1;
			if (c_s2) begin
				acc_q <= '0;
			end else if (v_s2) begin
				acc_q <= sum[64] ? '1 : sum[63:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		a_s1 <= op_a;
		b_s1 <= op_b;
		m_s1 <= ctl.mode;
		p_lo_s2 <= {16'd0, a_s1} * {16'd0, b_s1[31:0]};
		p_hi_s2 <= m_s1 ? ({16'd0, a_s1} * {16'd0, b_s1[63:32]}) : 48'd0;
	end

	assign prod = {1'b0, p_hi_s2, 32'd0} + {33'd0, p_lo_s2};
	assign term = (prod[80:64] != 17'd0) ? '1 : prod[63:0];
	assign sum  = {1'b0, acc_q} + {1'b0, term};
	assign acc  = acc_q;
endmodule

### hw/rtl/isra_div.sv
module isra_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] a,
	input  logic [63:0] n,
	input  logic [63:0] d,
	output logic        done,
	output logic [31:0] q
);
	// Restoring division, one numerator bit a cycle. a*n is formed in
	// two 32x32 partial products before the loop starts.
	logic [127:0] num_q;
	logic [63:0]  r_q;
	logic [31:0]  q_q;
	logic [7:0]   cnt_q;
	logic [1:0]   ph_q;
	logic         busy_q, sat_q;
	logic [63:0]  pl_q, ph64_q;
	logic [64:0]  rs;
	logic         ge;
	logic [95:0]  an;

	assign rs = {r_q, num_q[127]};
	assign ge = rs >= {1'b0, d};
	assign an = {32'd0, pl_q} + {ph64_q, 32'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			ph_q <= '0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				ph_q <= 2'd1;
			end else if (busy_q && ph_q == 2'd1) begin
				ph_q <= 2'd2;
				cnt_q <= 8'd128;
			end else if (busy_q && ph_q == 2'd2) begin
				if (cnt_q == 8'd1 || (ge && cnt_q > 8'd32)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
					ph_q <= 2'd0;
				end
				cnt_q <= cnt_q - 8'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			pl_q <= {32'd0, a} * {32'd0, n[31:0]};
			ph64_q <= {32'd0, a} * {32'd0, n[63:32]};
		end else if (ph_q == 2'd1) begin
			num_q <= {16'd0, an, 16'd0};
			r_q <= '0;
			q_q <= '0;
			sat_q <= 1'b0;
		end else if (ph_q == 2'd2) begin
			num_q <= {num_q[126:0], 1'b0};
			if (ge) begin
				r_q <= 64'(rs - {1'b0, d});
				if (cnt_q > 8'd32) sat_q <= 1'b1;
				q_q <= {q_q[30:0], 1'b1};
			end else begin
				r_q <= rs[63:0];
				q_q <= {q_q[30:0], 1'b0};
			end
		end
	end

	assign q = sat_q ? '1 : q_q;
endmodule

### hw/rtl/isra_abundance_unmixing.sv
// ISRA unmixing engine. Load endmember entries (opcode 0, one cycle each),
// then pixel samples (opcode 1). The sample at band band_count-1 closes the
// pixel and the block stays busy while one shared multiply-accumulate unit
// forms the numerators (T*B steps), then per iteration the reconstruction
// (B*T steps) and the denominators (T*B steps). Every walk is followed by
// a drain of the multiply-accumulate pipeline, and each divide ends early
// when its quotient saturates; a zero denominator skips the divide.
// Results then appear on result with done high for one cycle each,
// endmember order; the receiver cannot stall, so results must be taken as
// they come.
module isra_abundance_unmixing
	import isra_pkg::*;
#(
	parameter int MAX_BANDS   = 256,
	parameter int MAX_TARGETS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  isra_in_t    request,
	output logic        done,
	output isra_out_t   result,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data
);
	localparam int BW = $clog2(MAX_BANDS);
	localparam int TW = $clog2(MAX_TARGETS);
	localparam int EW = $clog2(MAX_TARGETS*MAX_BANDS);
	localparam int BL = (MAX_BANDS < 256) ? MAX_BANDS : 256;
	localparam int TL = (MAX_TARGETS < 16) ? MAX_TARGETS : 16;

	logic [15:0] em_mem [MAX_TARGETS*MAX_BANDS];
	logic [15:0] px_mem [MAX_BANDS];
	logic [63:0] rec_mem [MAX_BANDS];
	logic [63:0] num_q [MAX_TARGETS];
	logic [31:0] ab_q [MAX_TARGETS];
	logic        zf_q [MAX_TARGETS];

	logic [8:0] bands_q;
	logic [4:0] targets_q;
	logic [9:0] iters_q;
	logic [8:0] nb;
	logic [4:0] nt;

	isra_state_t state_q, state_d;
	logic [8:0] b_q;
	logic [4:0] t_q;
	logic [9:0] it_q;
	logic [2:0] drain_q;

	// Effective counts with the model's clamping.
	assign nb = (bands_q == 9'd0) ? 9'd1 : ((32'(bands_q) > BL) ? 9'(BL) : bands_q);
	assign nt = (targets_q == 5'd0) ? 5'd1 :
		((32'(targets_q) > TL) ? 5'(TL) : targets_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bands_q <= 9'd256;
			targets_q <= 5'd16;
			iters_q <= 10'd10;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BANDS:   bands_q <= cfg_data[8:0];
				REG_TARGETS: targets_q <= cfg_data[4:0];
				REG_ITERS:   iters_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic accept;
	logic closes;
	assign accept = start && !busy;
	assign closes = accept && request.opcode == OP_SAMPLE &&
		{1'b0, request.band_index} == 9'(nb - 9'd1);

	// Walk addresses: b_q over bands, t_q over targets.
	logic [TW-1:0] t_idx;
	logic [BW-1:0] b_idx;
	assign t_idx = TW'(t_q);
	assign b_idx = BW'(b_q);

	logic [EW-1:0] em_wr_addr;
	logic [EW-1:0] em_rd_addr;
	assign em_wr_addr = EW'(32'(request.target_index)*MAX_BANDS + 32'(request.band_index));
	assign em_rd_addr = EW'(32'(t_idx)*MAX_BANDS + 32'(b_idx));

	always_ff @(posedge clk) begin
		if (accept && request.opcode == OP_LOAD &&
			32'(request.target_index) < MAX_TARGETS && 32'(request.band_index) < MAX_BANDS)
			em_mem[em_wr_addr] <= request.value;
		if (accept && request.opcode == OP_SAMPLE && 32'(request.band_index) < MAX_BANDS)
			px_mem[BW'(request.band_index)] <= request.value;
	end

	// Registered reads feeding the MAC.
	logic [15:0] em_rd_s1;
	logic [15:0] px_rd_s1;
	logic [63:0] rec_rd_s1;
	logic [31:0] ab_rd_s1;
	logic        step_s1;
	logic [1:0]  kind_s1;
	isra_mac_ctl_t mac_ctl;
	logic [63:0] mac_acc;
	logic        step;

	assign step = state_q == ST_NUM || state_q == ST_REC || state_q == ST_DEN;

	always_ff @(posedge clk) begin
		em_rd_s1 <= em_mem[em_rd_addr];
		px_rd_s1 <= px_mem[b_idx];
		rec_rd_s1 <= rec_mem[b_idx];
		ab_rd_s1 <= ab_q[t_idx];
		kind_s1 <= (state_q == ST_NUM) ? 2'd0 : ((state_q == ST_REC) ? 2'd1 : 2'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) step_s1 <= 1'b0;
		else step_s1 <= step;
	end

	logic mac_clear;
	assign mac_ctl.clear = mac_clear;
	assign mac_ctl.valid = step_s1;
	assign mac_ctl.mode  = kind_s1 == 2'd2;

	isra_mac u_mac (
		.clk(clk), .arst_n(arst_n), .ctl(mac_ctl),
		.op_a(em_rd_s1),
		.op_b(kind_s1 == 2'd0 ? {48'd0, px_rd_s1} :
			(kind_s1 == 2'd1 ? {32'd0, ab_rd_s1} : rec_rd_s1)),
		.acc(mac_acc)
	);

	logic        div_start, div_done;
	logic [31:0] div_q;
	logic [63:0] den_q;
	isra_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.a(ab_q[t_idx]), .n(num_q[t_idx]), .d(den_q),
		.done(div_done), .q(div_q)
	);

	// Inner walk finishes when the inner index reaches its end.
	logic inner_last;
	always_comb begin
		unique case (state_q)
			ST_REC:  inner_last = t_q == 5'(nt - 5'd1);
			default: inner_last = b_q == 9'(nb - 9'd1);
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (closes) state_d = ST_NUM;
			ST_NUM: if (inner_last) state_d = ST_NUM_END;
			ST_NUM_END: if (drain_q == 3'd4)
				state_d = (t_q == 5'(nt - 5'd1)) ?
					((iters_q == 10'd0) ? ST_EMIT : ST_REC) : ST_NUM;
			ST_REC: if (inner_last) state_d = ST_REC_END;
			ST_REC_END: if (drain_q == 3'd4)
				state_d = (b_q == 9'(nb - 9'd1)) ? ST_DEN : ST_REC;
			ST_DEN: if (inner_last) state_d = ST_DEN_END;
			ST_DEN_END: if (drain_q == 3'd4) state_d = ST_DIV_START;
			ST_DIV_START: state_d = (den_q == 64'd0) ?
				((t_q == 5'(nt - 5'd1)) ?
					((it_q == 10'(iters_q - 10'd1)) ? ST_EMIT : ST_REC) : ST_DEN)
				: ST_DIV_WAIT;
			ST_DIV_WAIT: if (div_done)
				state_d = (t_q == 5'(nt - 5'd1)) ?
					((it_q == 10'(iters_q - 10'd1)) ? ST_EMIT : ST_REC) : ST_DEN;
			ST_EMIT: if (t_q == 5'(nt - 5'd1)) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = state_q != ST_IDLE;
		div_start = state_q == ST_DIV_START && den_q != 64'd0;
		mac_clear = (state_q == ST_NUM_END || state_q == ST_REC_END ||
			state_q == ST_DEN_END) && drain_q == 3'd4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			b_q <= '0;
			t_q <= '0;
			it_q <= '0;
			drain_q <= '0;
			done <= 1'b0;
			result <= '0;
			den_q <= '0;
			for (int i = 0; i < MAX_TARGETS; i++) begin
				num_q[i] <= '0;
				ab_q[i] <= '0;
				zf_q[i] <= 1'b0;
			end
		end else begin
			state_q <= state_d;
			done <= 1'b0;
			drain_q <= '0;
			unique case (state_q)
				ST_IDLE: begin
					b_q <= '0;
					t_q <= '0;
					it_q <= '0;
				end
				ST_NUM, ST_DEN: if (!inner_last) b_q <= b_q + 9'd1;
				ST_REC: if (!inner_last) t_q <= t_q + 5'd1;
				ST_NUM_END: begin
					drain_q <= drain_q + 3'd1;
					if (drain_q == 3'd4) begin
						num_q[t_idx] <= mac_acc;
						ab_q[t_idx] <= 32'h0001_0000;
						zf_q[t_idx] <= 1'b0;
						b_q <= '0;
						t_q <= (t_q == 5'(nt - 5'd1)) ? 5'd0 : t_q + 5'd1;
					end
				end
				ST_REC_END: begin
					drain_q <= drain_q + 3'd1;
					if (drain_q == 3'd4) begin
						t_q <= '0;
						b_q <= (b_q == 9'(nb - 9'd1)) ? 9'd0 : b_q + 9'd1;
					end
				end
				ST_DEN_END: begin
					drain_q <= drain_q + 3'd1;
					if (drain_q == 3'd4) den_q <= mac_acc;
				end
				ST_DIV_START, ST_DIV_WAIT: begin
					if (state_q == ST_DIV_START && den_q == 64'd0) begin
						ab_q[t_idx] <= '1;
						zf_q[t_idx] <= 1'b1;
					end else if (state_q == ST_DIV_WAIT && div_done) begin
						ab_q[t_idx] <= div_q;
					end
					if (state_d != state_q && state_d != ST_DIV_WAIT) begin
						b_q <= '0;
						if (t_q == 5'(nt - 5'd1)) begin
							t_q <= '0;
							it_q <= it_q + 10'd1;
						end else begin
							t_q <= t_q + 5'd1;
						end
					end
				end
				ST_EMIT: begin
					done <= 1'b1;
					result.out_target <= t_q[3:0];
					result.abundance <= ab_q[t_idx];
					result.zero_denominator <= zf_q[t_idx];
					result.last <= t_q == 5'(nt - 5'd1);
					t_q <= t_q + 5'd1;
				end
				default: ;
			endcase
		end
	end

	// Reconstruction entries are written, one per band, at the end of each walk over the targets.
	always_ff @(posedge clk) begin
		if (state_q == ST_REC_END && drain_q == 3'd4) rec_mem[b_idx] <= mac_acc;
	end

`ifndef SYNTHESIS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !(state_q == ST_IDLE)) else $error("busy while idle");
	a_done_only_emit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == ST_EMIT) else $error("result outside emit");
	a_div_one: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> state_q == ST_DIV_WAIT) else $error("divider start lost");
`endif
endmodule
